// ===== rtl/core/cwc_pkg.sv =====
// Shared constants, register codes and key-schedule functions for the chained word cipher.
package cwc_pkg;

  localparam int WordW   = 32;
  localparam int KeyW    = 64;
  localparam int RotRight = 13;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CIPHER_KEY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_VECTOR  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECRYPT_MODE = 2'd2;

  // Mixing table shared by the rotate amount and the index vector
  localparam logic [7:0] MIX_TAB [32] = '{
    8'h7C, 8'h23, 8'hA9, 8'h5F, 8'hD4, 8'h3E, 8'h81, 8'h17,
    8'hB2, 8'h6A, 8'hC8, 8'h90, 8'h4D, 8'h1B, 8'hFE, 8'h39,
    8'h74, 8'hE1, 8'h0C, 8'hAA, 8'h5D, 8'hCB, 8'h19, 8'h82,
    8'hF3, 8'h60, 8'h2A, 8'h96, 8'hDE, 8'h48, 8'h13, 8'hBD
  };

  // Logical rotate left by 0..31
  function automatic logic [WordW-1:0] rot_left(input logic [WordW-1:0] x,
                                                input logic [4:0] r);
    logic [2*WordW-1:0] dbl;
    dbl = {x, x} << r;
    return dbl[2*WordW-1:WordW];
  endfunction

  // Byte-select vector for block index n: four chained lookups, then rotate right
  function automatic logic [WordW-1:0] index_vector(input logic [WordW-1:0] n);
    logic [WordW-1:0] v;
    v = n | {24'd0, MIX_TAB[n[4:0]]};
    v = v | {16'd0, MIX_TAB[v[4:0]], 8'd0};
    v = v | {8'd0, MIX_TAB[v[4:0]], 16'd0};
    v = v | {MIX_TAB[v[4:0]], 24'd0};
    return rot_left(v, 5'(WordW - RotRight));
  endfunction

  // Key word from one key half: table-driven rotate, then byte permutation by vec
  function automatic logic [WordW-1:0] key_word(input logic [WordW-1:0] half,
                                                input logic [WordW-1:0] vec);
    logic [WordW-1:0] r;
    logic [WordW-1:0] kw;
    logic [1:0]       sel;
    r  = rot_left(half, MIX_TAB[half[4:0]][4:0]);
    kw = '0;
    for (int j = 0; j < 4; j++) begin
      sel = vec[8*(3-j) +: 2];
      kw[8*j +: 8] = r[8*sel +: 8];
    end
    return kw;
  endfunction

endpackage

// ===== rtl/core/cwc_keygen.sv =====
// Per-block key word: both key halves scheduled for the current block index and combined.
module cwc_keygen (
  input  logic [cwc_pkg::KeyW-1:0]  cipher_key,
  input  logic [cwc_pkg::WordW-1:0] block_index,
  output logic [cwc_pkg::WordW-1:0] key_word
);

  logic [cwc_pkg::WordW-1:0] vec;
  logic [cwc_pkg::WordW-1:0] half_a;
  logic [cwc_pkg::WordW-1:0] half_b;

  // Swap key halves on odd blocks
  always_comb begin
    if (block_index[0]) begin
      half_a = cipher_key[cwc_pkg::KeyW-1:cwc_pkg::WordW];
      half_b = cipher_key[cwc_pkg::WordW-1:0];
    end else begin
      half_a = cipher_key[cwc_pkg::WordW-1:0];
      half_b = cipher_key[cwc_pkg::KeyW-1:cwc_pkg::WordW];
    end
  end

  // One index vector serves both halves
  assign vec      = cwc_pkg::index_vector(block_index);
  assign key_word = cwc_pkg::key_word(half_a, vec) ^ cwc_pkg::key_word(half_b, vec);

endmodule

// ===== rtl/core/chained_word_cipher.sv =====
// Top level of the chained word cipher: input register, chaining logic, result register.
//
// Chained word cipher, one 32-bit word in and one out per transfer. A word is
// captured in an input register; once the result register is free or being
// drained, the key word for the current block index is built, XORed with the
// word and the chaining word, and loaded into the result register. The block
// sustains one word per clock while the output is not stalled: the chaining
// word and the block index are updated in the same cycle as the result
// register load, which is the loop that sets the rate. tuser high on an input
// word restarts the index at zero and the chaining word from init_vector.
// Encrypt chains on the result, decrypt chains on the incoming ciphertext.
// Write the configuration registers only while no word is in flight.
module chained_word_cipher (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [cwc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cwc_pkg::KeyW-1:0]      cfg_data,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [31:0] data_word
  input  logic                          s_tuser,   // [0] first_block
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata    // [31:0] result_word
);

  logic [cwc_pkg::KeyW-1:0]  cipher_key;
  logic [cwc_pkg::WordW-1:0] init_vector;
  logic                      decrypt_mode;
  logic [cwc_pkg::WordW-1:0] chain_word;
  logic [cwc_pkg::WordW-1:0] block_index;

  logic                      in_valid;
  logic [cwc_pkg::WordW-1:0] in_data;
  logic                      in_first;
  logic                      out_valid;
  logic [cwc_pkg::WordW-1:0] result_word;

  logic                      advance;
  logic [cwc_pkg::WordW-1:0] chain_cur;
  logic [cwc_pkg::WordW-1:0] index_cur;
  logic [cwc_pkg::WordW-1:0] key_word;
  logic [cwc_pkg::WordW-1:0] res;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key   <= '0;
      init_vector  <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cwc_pkg::CFG_CIPHER_KEY:   cipher_key   <= cfg_data;
        cwc_pkg::CFG_INIT_VECTOR:  init_vector  <= cfg_data[cwc_pkg::WordW-1:0];
        cwc_pkg::CFG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Move the held word on when the result register is free or being drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = result_word;

  // Restart index and chaining on a first block
  assign chain_cur = in_first ? init_vector : chain_word;
  assign index_cur = in_first ? '0 : block_index;

  cwc_keygen u_keygen (
    .cipher_key  (cipher_key),
    .block_index (index_cur),
    .key_word    (key_word)
  );

  assign res = in_data ^ chain_cur ^ key_word;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_word <= res;
    end
  end

  // Chaining state advances with each word
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_word  <= '0;
      block_index <= '0;
    end else if (advance) begin
      chain_word  <= decrypt_mode ? in_data : res;
      block_index <= index_cur + 32'd1;
    end
  end

  // Index steps by one per word unless restarted
  ast_index_step: assert property (@(posedge clk) disable iff (rst)
    advance && !in_first |=> block_index == $past(block_index) + 32'd1)
    else $error("block index did not step");

  ast_index_restart: assert property (@(posedge clk) disable iff (rst)
    advance && in_first |=> block_index == 32'd1)
    else $error("block index did not restart");

  // Encrypt chains on the result just produced
  ast_chain_encrypt: assert property (@(posedge clk) disable iff (rst)
    advance && !decrypt_mode |=> chain_word == m_tdata)
    else $error("encrypt chaining word differs from result");

  // Decrypt chains on the incoming ciphertext
  ast_chain_decrypt: assert property (@(posedge clk) disable iff (rst)
    advance && decrypt_mode |=> chain_word == $past(in_data))
    else $error("decrypt chaining word differs from input");

endmodule
